### rtl/sfr_pkg.sv
package sfr_pkg;

  localparam logic [7:0] CRC_POLY        = 8'h8C;
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hAA;
  localparam logic [7:0] MIN_LENGTH      = 8'd5;

  localparam logic [7:0] CFG_HEADER_FIRST  = 8'd0;
  localparam logic [7:0] CFG_HEADER_SECOND = 8'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [15:0] speed;
    logic signed [15:0] angle;
    logic [7:0]        flag;
    logic [7:0]        length;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] index;
    logic [7:0] data;
  } cfg_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/sfr_parser.sv
module sfr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          res_valid_o,
  output sfr_pkg::res_t res_o
);
  import sfr_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT1   = 5'b00001,
    PH_HUNT2   = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [7:0]  index_q, index_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] speed_q, speed_d;
  logic [15:0] angle_q, angle_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  crc_next;
  logic [7:0]  index_inc;
  logic [1:0]  status;

  assign crc_next  = crc8_step(crc_q, rx_byte_i);
  assign index_inc = index_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HEADER_FIRST_RST;
      hdr_second_q <= HEADER_SECOND_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_HEADER_FIRST) begin
        hdr_first_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_HEADER_SECOND) begin
        hdr_second_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    index_d     = index_q;
    length_d    = length_q;
    crc_d       = crc_q;
    speed_d     = speed_q;
    angle_d     = angle_q;
    last_d      = last_q;
    status      = ST_OK;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (length_q < MIN_LENGTH) begin
      status = ST_SHORT;
    end else if (rx_byte_i != crc_q) begin
      status = ST_CRC_ERR;
    end
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == hdr_first_q) begin
            phase_d  = PH_HUNT2;
            crc_d    = crc8_step(8'h00, hdr_first_q);
            index_d  = '0;
            length_d = '0;
            speed_d  = '0;
            angle_d  = '0;
            last_d   = '0;
          end
        end
        PH_HUNT2: begin
          if (rx_byte_i == hdr_second_q) begin
            crc_d   = crc_next;
            phase_d = PH_LEN;
          end else if (rx_byte_i == hdr_first_q) begin
            phase_d  = PH_HUNT2;
            crc_d    = crc8_step(8'h00, hdr_first_q);
            index_d  = '0;
            length_d = '0;
            speed_d  = '0;
            angle_d  = '0;
            last_d   = '0;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LEN: begin
          crc_d    = crc_next;
          length_d = rx_byte_i;
          index_d  = '0;
          phase_d  = (rx_byte_i == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_d = crc_next;
          case (index_q)
            8'd0:    speed_d = {speed_q[15:8], rx_byte_i};
            8'd1:    speed_d = {rx_byte_i, speed_q[7:0]};
            8'd2:    angle_d = {angle_q[15:8], rx_byte_i};
            8'd3:    angle_d = {rx_byte_i, angle_q[7:0]};
            default: ;
          endcase
          last_d  = rx_byte_i;
          index_d = index_inc;
          if (index_inc >= length_q) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          res_valid_o  = 1'b1;
          res_o.status = status;
          res_o.speed  = (status == ST_OK) ? speed_q : '0;
          res_o.angle  = (status == ST_OK) ? angle_q : '0;
          res_o.flag   = (status == ST_OK) ? last_q : '0;
          res_o.length = length_q;
          phase_d      = PH_HUNT1;
          index_d      = '0;
          crc_d        = '0;
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      index_q  <= '0;
      length_q <= '0;
      crc_q    <= '0;
      speed_q  <= '0;
      angle_q  <= '0;
      last_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      index_q  <= index_d;
      length_q <= length_d;
      crc_q    <= crc_d;
      speed_q  <= speed_d;
      angle_q  <= angle_d;
      last_q   <= last_d;
    end
  end

  a_zero_len_to_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PH_LEN && rx_byte_i == 8'd0) |=> phase_q == PH_CRC)
    else $error("zero length did not go to crc byte");

  a_result_resets_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == PH_HUNT1 && crc_q == 8'd0))
    else $error("result not followed by hunt");

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (index_q < length_q))
    else $error("payload index past length");

endmodule

### rtl/sfr_out_buf.sv
module sfr_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sfr_pkg::res_t out_data_o
);
  import sfr_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (!out_valid_q || pop) begin
        out_valid_q <= push_i;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output is empty");

  a_stalled_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !pop && !skid_valid_q) |=> skid_valid_q)
    else $error("item lost on stalled output");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item not moved to output");

endmodule

### rtl/serial_frame_receiver_crc8.sv
// channel   direction  handshake               payload
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_stall_o    rx_byte_i
// out       out        out_valid_o/out_stall_i  frame_status_o, speed_value_o, angle_value_o,
//                                               control_flag_o, payload_length_o
//
// one byte per cycle unless stalled; the frame state updates in the cycle a byte is accepted
// a result is registered into the output buffer when its crc byte is accepted
// a two-entry output buffer lets input run on while one result waits;
// in_stall_o rises only when both entries hold results
// reset clears the frame state to header hunt and the headers to 0x55, 0xaa
module serial_frame_receiver_crc8 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_status_o,
  output logic signed [15:0] speed_value_o,
  output logic signed [15:0] angle_value_o,
  output logic [7:0]         control_flag_o,
  output logic [7:0]         payload_length_o
);
  import sfr_pkg::*;

  cfg_t cfg;
  logic accept;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;
  assign accept      = in_valid_i && !in_stall_o;

  sfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign frame_status_o   = out_data.status;
  assign speed_value_o    = out_data.speed;
  assign angle_value_o    = out_data.angle;
  assign control_flag_o   = out_data.flag;
  assign payload_length_o = out_data.length;

endmodule

### test/serial_frame_receiver_crc8_test.sv
module serial_frame_receiver_crc8_test;
  import sfr_pkg::*;

  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         HOLD_CYCLES      = 150;
  localparam logic [7:0] REG_INDEX_UNUSED = 8'd2;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    READ_LENGTH,
    READ_PAYLOAD,
    READ_CRC
  } frame_phase_e;

  logic               clk_i;
  logic               rst_n          = 1'b0;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index      = 8'd0;
  logic [7:0]         cfg_data       = 8'd0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte        = 8'd0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         frame_status;
  logic signed [15:0] speed_value;
  logic signed [15:0] angle_value;
  logic [7:0]         control_flag;
  logic [7:0]         payload_length;

  // copy of the header registers and the frame tracking state
  logic [7:0]   hdr_first_cfg  = HEADER_FIRST_RST;
  logic [7:0]   hdr_second_cfg = HEADER_SECOND_RST;
  frame_phase_e trk_phase      = HUNT_FIRST;
  logic [7:0]   trk_crc        = 8'd0;
  logic [7:0]   trk_taken      = 8'd0;
  logic [7:0]   trk_len        = 8'd0;
  logic [15:0]  trk_speed      = 16'd0;
  logic [15:0]  trk_angle      = 16'd0;
  logic [7:0]   trk_last       = 8'd0;

  res_t       pending_frames[$];
  logic [7:0] payload_q[$];

  int items_sent    = 0;
  int errors        = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  serial_frame_receiver_crc8 DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_status_o  (frame_status),
    .speed_value_o   (speed_value),
    .angle_value_o   (angle_value),
    .control_flag_o  (control_flag),
    .payload_length_o(payload_length)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ data[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void open_frame();
    trk_phase = HUNT_SECOND;
    trk_crc   = crc8_update(8'd0, hdr_first_cfg);
    trk_taken = 8'd0;
    trk_len   = 8'd0;
    trk_speed = 16'd0;
    trk_angle = 16'd0;
    trk_last  = 8'd0;
  endfunction

  function automatic void track_frame_byte(input logic [7:0] b);
    res_t r;
    case (trk_phase)
      HUNT_FIRST: begin
        if (b == hdr_first_cfg) open_frame();
      end
      HUNT_SECOND: begin
        if (b == hdr_second_cfg) begin
          trk_crc   = crc8_update(trk_crc, b);
          trk_phase = READ_LENGTH;
        end else if (b == hdr_first_cfg) begin
          open_frame();
        end else begin
          trk_phase = HUNT_FIRST;
        end
      end
      READ_LENGTH: begin
        trk_crc   = crc8_update(trk_crc, b);
        trk_len   = b;
        trk_taken = 8'd0;
        trk_phase = (b == 8'd0) ? READ_CRC : READ_PAYLOAD;
      end
      READ_PAYLOAD: begin
        trk_crc = crc8_update(trk_crc, b);
        case (trk_taken)
          8'd0: trk_speed[7:0]  = b;
          8'd1: trk_speed[15:8] = b;
          8'd2: trk_angle[7:0]  = b;
          8'd3: trk_angle[15:8] = b;
          default: ;
        endcase
        trk_last  = b;
        trk_taken = trk_taken + 8'd1;
        if (trk_taken >= trk_len) trk_phase = READ_CRC;
      end
      default: begin
        if (trk_len < MIN_LENGTH) begin
          r.status = ST_SHORT;
        end else if (b != trk_crc) begin
          r.status = ST_CRC_ERR;
        end else begin
          r.status = ST_OK;
        end
        r.speed  = (r.status == ST_OK) ? trk_speed : 16'd0;
        r.angle  = (r.status == ST_OK) ? trk_angle : 16'd0;
        r.flag   = (r.status == ST_OK) ? trk_last : 8'd0;
        r.length = trk_len;
        pending_frames.push_back(r);
        trk_phase = HUNT_FIRST;
        trk_taken = 8'd0;
        trk_crc   = 8'd0;
      end
    endcase
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // result checking
  always @(posedge clk_i) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d length %0d",
                 $time, frame_status, payload_length);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        compare_field("frame_status", int'(want.status), int'(frame_status));
        compare_field("speed_value", int'(want.speed), int'(speed_value));
        compare_field("angle_value", int'(want.angle), int'(angle_value));
        compare_field("control_flag", int'(want.flag), int'(control_flag));
        compare_field("payload_length", int'(want.length), int'(payload_length));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    track_frame_byte(b);
  endtask

  // header, length, everything in payload_q, then the crc once the payload is complete
  task automatic send_frame(input logic [7:0] len, input bit bad_crc);
    logic [7:0] crc;
    crc = crc8_update(8'd0, hdr_first_cfg);
    send_byte(hdr_first_cfg);
    crc = crc8_update(crc, hdr_second_cfg);
    send_byte(hdr_second_cfg);
    crc = crc8_update(crc, len);
    send_byte(len);
    foreach (payload_q[i]) begin
      crc = crc8_update(crc, payload_q[i]);
      send_byte(payload_q[i]);
    end
    if (payload_q.size() >= len) begin
      if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(7));
      send_byte(crc);
    end
  endtask

  task automatic fill_payload(input int count);
    payload_q.delete();
    repeat (count) payload_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [7:0] index, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_HEADER_FIRST) begin
      hdr_first_cfg = data;
    end else if (index == CFG_HEADER_SECOND) begin
      hdr_second_cfg = data;
    end
  endtask

  task automatic run_random_traffic(input int item_budget);
    int         stop_at;
    int         pick;
    int         n;
    logic [7:0] len;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        n = $urandom_range(99);
        if (n < 80) begin
          len = 8'($urandom_range(8, 5));
        end else if (n < 95) begin
          len = 8'($urandom_range(4, 0));
        end else begin
          len = 8'($urandom_range(40, 9));
        end
        fill_payload(int'(len));
        send_frame(len, $urandom_range(99) < 20);
      end else if (pick < 85) begin
        // broken header pair
        send_byte(hdr_first_cfg);
        send_byte(($urandom_range(1) == 0) ? hdr_first_cfg : 8'($urandom_range(255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        // truncated frame, the next bytes land in its payload
        len = 8'($urandom_range(12, 5));
        fill_payload(int'($urandom_range(len - 1)));
        send_frame(len, 1'b0);
      end
    end
  endtask

  task automatic test_good_frame();
    payload_q = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF};
    send_frame(8'd5, 1'b0);
  endtask

  task automatic test_header_resync();
    send_byte(hdr_first_cfg);
    send_byte(8'h12);
    send_byte(hdr_first_cfg);
    payload_q.delete();
    send_frame(8'd0, 1'b0);
  endtask

  task automatic test_short_length();
    payload_q = '{8'h7E, 8'h81};
    send_frame(8'd2, 1'b1);
  endtask

  task automatic test_crc_mismatch();
    payload_q = '{8'h34, 8'h12, 8'hCD, 8'hAB, 8'h5C};
    send_frame(8'd5, 1'b1);
  endtask

  task automatic test_register_writes();
    drain();
    write_register(REG_INDEX_UNUSED, 8'hC3);
    fill_payload(6);
    send_frame(8'd6, 1'b0);
    drain();
    write_register(CFG_HEADER_FIRST, 8'h00);
    write_register(CFG_HEADER_SECOND, 8'hFF);
    fill_payload(5);
    send_frame(8'd5, 1'b0);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 21;
    recv_idle_pct = 64;
    run_random_traffic(300);
  endtask

  task automatic test_random_receiver_idle();
    drain();
    write_register(CFG_HEADER_FIRST, 8'hFF);
    write_register(CFG_HEADER_SECOND, 8'h00);
    send_idle_pct = 64;
    recv_idle_pct = 21;
    run_random_traffic(300);
  endtask

  task automatic test_output_backpressure();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (12) begin
      if ($urandom_range(1) == 0) begin
        payload_q.delete();
        send_frame(8'd0, 1'b0);
      end else begin
        fill_payload(5);
        send_frame(8'd5, 1'b0);
      end
    end
    drain();
  endtask

  task automatic test_random_streaming();
    drain();
    write_register(CFG_HEADER_FIRST, 8'h5A);
    write_register(CFG_HEADER_SECOND, 8'h5A);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(70);
    drain();
    fill_payload(255);
    send_frame(8'd255, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 21;
    recv_idle_pct = 64;
    test_good_frame();
    test_header_resync();
    test_short_length();
    test_crc_mismatch();
    test_register_writes();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_output_backpressure();
    test_random_streaming();
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/sfr_out_buf.sv
rtl/serial_frame_receiver_crc8.sv
test/serial_frame_receiver_crc8_test.sv
